### rtl/core/ubvb_pkg.sv
// shared types, constants and the boolean function helper for the bit vector op
`timescale 1ns / 1ps
`default_nettype none

package ubvb_pkg;

   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 14;
   localparam int LEN_W       = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int OFFSET_W    = 3;
   localparam int ROP_W       = 4;

   // longest operation in bits; longer lengths saturate here
   localparam logic [LEN_W-1:0] MAX_BITS = LEN_W'(65536);

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_ROP         = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_X_OFFSET    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_OFFSET    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_OFFSET = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_LENGTH  = CSR_INDEX_W'(4);

   // operation setup seen by the byte datapath
   typedef struct packed {
      logic [ROP_W-1:0]    rop;
      logic [OFFSET_W-1:0] x_offset;
      logic [OFFSET_W-1:0] y_offset;
      logic [OFFSET_W-1:0] dest_offset;
      logic [INDEX_W-1:0]  end_byte;   // byte holding the first bit past the span
      logic [OFFSET_W-1:0] end_bit;    // bit position of that bit in its byte
   } ubvb_cfg_type;

   // one result word
   typedef struct packed {
      logic [BYTE_W-1:0]  result_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_out;
   } ubvb_rsp_type;

   // bitwise raster op: rop bit 0 picks x&y, bit 1 x&~y, bit 2 ~x&y, bit 3 ~x&~y
   function automatic logic [BYTE_W-1:0] rop_apply(input logic [ROP_W-1:0] rop,
                                                   input logic [BYTE_W-1:0] x,
                                                   input logic [BYTE_W-1:0] y);
      logic [BYTE_W-1:0] r;
      r = '0;
      if (rop[0]) r = r | (x & y);
      if (rop[1]) r = r | (x & ~y);
      if (rop[2]) r = r | (~x & y);
      if (rop[3]) r = r | (~x & ~y);
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ubvb_channels.sv
// valid/ready channel interfaces for source bytes in and destination bytes out
`timescale 1ns / 1ps
`default_nettype none

interface ubvb_req_if;
   import ubvb_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] x_byte;
   logic [BYTE_W-1:0] y_byte;
   logic [BYTE_W-1:0] old_dest_byte;
   logic              last_in;

   modport source (output valid, x_byte, y_byte, old_dest_byte, last_in, input ready);
   modport sink   (input valid, x_byte, y_byte, old_dest_byte, last_in, output ready);
endinterface

interface ubvb_rsp_if;
   import ubvb_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  result_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               last_out;

   modport source (output valid, result_byte, byte_index, last_out, input ready);
   modport sink   (input valid, result_byte, byte_index, last_out, output ready);
endinterface

`default_nettype wire

### rtl/core/ubvb_byte_op.sv
// one destination byte: funnel shift of both sources, raster op and span merge
`timescale 1ns / 1ps
`default_nettype none

module ubvb_byte_op (
   input  ubvb_pkg::ubvb_cfg_type          cfg,
   input  logic [ubvb_pkg::INDEX_W-1:0]    byte_idx,
   input  logic [3*ubvb_pkg::BYTE_W-1:0]   win_x,
   input  logic [3*ubvb_pkg::BYTE_W-1:0]   win_y,
   input  logic [ubvb_pkg::BYTE_W-1:0]     old_byte,
   output logic [ubvb_pkg::BYTE_W-1:0]     new_byte
);
   import ubvb_pkg::*;

   logic [3:0]        sh_x;
   logic [3:0]        sh_y;
   logic [BYTE_W-1:0] x_al;
   logic [BYTE_W-1:0] y_al;
   logic [BYTE_W-1:0] op_byte;
   logic [BYTE_W-1:0] mask;
   logic              first_byte;
   logic              below_end;
   logic              at_end;

   // align source bits to destination bit positions, msb first
   assign sh_x = 4'(BYTE_W) + 4'(cfg.dest_offset) - 4'(cfg.x_offset);
   assign sh_y = 4'(BYTE_W) + 4'(cfg.dest_offset) - 4'(cfg.y_offset);
   assign x_al = BYTE_W'(win_x >> sh_x);
   assign y_al = BYTE_W'(win_y >> sh_y);

   assign op_byte = rop_apply(cfg.rop, x_al, y_al);

   // bits of this byte that fall inside the destination span
   assign first_byte = (byte_idx == '0);
   assign below_end  = (byte_idx < cfg.end_byte);
   assign at_end     = (byte_idx == cfg.end_byte);

   always_comb begin
      for (int t = 0; t < BYTE_W; t++) begin
         mask[BYTE_W-1-t] = (!first_byte || (OFFSET_W'(t) >= cfg.dest_offset)) &&
                            (below_end || (at_end && (OFFSET_W'(t) < cfg.end_bit)));
      end
   end

   assign new_byte = (op_byte & mask) | (old_byte & ~mask);

endmodule

`default_nettype wire

### rtl/core/unaligned_bit_vector_boolean_op.sv
// top level: unaligned bit vector boolean op with csr, history and result queue
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   req_ch  | in  | valid/ready        | x_byte, y_byte, old_dest_byte, last_in
//   rsp_ch  | out | valid/ready        | result_byte, byte_index, last_out
//   csr     | in  | csr_we, no stall   | csr_index, csr_wdata
//
// one word is taken per cycle while the input does not stall; a word is held in
// the input register, then its destination bytes go into an output queue of
// RSP_DEPTH words. the last word of an operation yields two result words (one
// if it is also the first); the queue absorbs that and input stalls only when
// the queue has fewer than two free entries. reset is synchronous, active high,
// sets bit length to 1 and clears other csrs, the byte history and the queue.
`timescale 1ns / 1ps
`default_nettype none

module unaligned_bit_vector_boolean_op #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   ubvb_req_if.sink                          req_ch,
   ubvb_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [ubvb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ubvb_pkg::LEN_W-1:0]        csr_wdata
);
   import ubvb_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
      logic [BYTE_W-1:0] old_dest_byte;
      logic              last_in;
   } item_type;

   // csr registers
   logic [ROP_W-1:0]    rop_ff;
   logic [OFFSET_W-1:0] x_offset_ff;
   logic [OFFSET_W-1:0] y_offset_ff;
   logic [OFFSET_W-1:0] dest_offset_ff;
   logic [LEN_W-1:0]    bit_length_ff;

   // input register and byte history
   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_ff;
   logic [BYTE_W-1:0]   prev_x_ff, prev_y_ff, prev_dest_ff, prev2_x_ff, prev2_y_ff;
   logic [INDEX_W-1:0]  counter_ff, counter_in;

   // result queue
   ubvb_rsp_type        rsp_mem [RSP_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                advance;
   logic                req_accept;
   logic                push_a, push_b, pop;
   logic [PTR_W-1:0]    wr_ptr_next;
   logic [PTR_W-1:0]    b_addr;
   logic [LEN_W-1:0]    len_eff;
   logic [LEN_W-1:0]    span_end;
   ubvb_cfg_type        cfg;
   ubvb_rsp_type        rsp_a, rsp_b;
   logic [INDEX_W-1:0]  idx_a;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RSP_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // csr write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         rop_ff         <= '0;
         x_offset_ff    <= '0;
         y_offset_ff    <= '0;
         dest_offset_ff <= '0;
         bit_length_ff  <= LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROP:         rop_ff         <= csr_wdata[ROP_W-1:0];
            CSR_X_OFFSET:    x_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            CSR_Y_OFFSET:    y_offset_ff    <= csr_wdata[OFFSET_W-1:0];
            CSR_DEST_OFFSET: dest_offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_BIT_LENGTH:  bit_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // span end in bits, saturated length plus destination offset
   assign len_eff  = (bit_length_ff > MAX_BITS) ? MAX_BITS : bit_length_ff;
   assign span_end = len_eff + LEN_W'(dest_offset_ff);

   assign cfg.rop         = rop_ff;
   assign cfg.x_offset    = x_offset_ff;
   assign cfg.y_offset    = y_offset_ff;
   assign cfg.dest_offset = dest_offset_ff;
   assign cfg.end_byte    = span_end[LEN_W-1:OFFSET_W];
   assign cfg.end_bit     = span_end[OFFSET_W-1:0];

   // input handshake: stage moves on when the queue has room for two words
   assign advance      = s1_valid_ff && (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.x_byte        <= req_ch.x_byte;
         s1_ff.y_byte        <= req_ch.y_byte;
         s1_ff.old_dest_byte <= req_ch.old_dest_byte;
         s1_ff.last_in       <= req_ch.last_in;
      end
   end

   // previous byte: index k-1 with window k-2, k-1, k
   assign idx_a = counter_ff - 1'b1;

   ubvb_byte_op u_byte_prev (
      .cfg      (cfg),
      .byte_idx (idx_a),
      .win_x    ({prev2_x_ff, prev_x_ff, s1_ff.x_byte}),
      .win_y    ({prev2_y_ff, prev_y_ff, s1_ff.y_byte}),
      .old_byte (prev_dest_ff),
      .new_byte (rsp_a.result_byte)
   );
   assign rsp_a.byte_index = idx_a;
   assign rsp_a.last_out   = 1'b0;

   // final byte: index k with window k-1, k and zeros past the stream
   ubvb_byte_op u_byte_last (
      .cfg      (cfg),
      .byte_idx (counter_ff),
      .win_x    ({prev_x_ff, s1_ff.x_byte, BYTE_W'(0)}),
      .win_y    ({prev_y_ff, s1_ff.y_byte, BYTE_W'(0)}),
      .old_byte (s1_ff.old_dest_byte),
      .new_byte (rsp_b.result_byte)
   );
   assign rsp_b.byte_index = counter_ff;
   assign rsp_b.last_out   = 1'b1;

   // byte history and word counter, cleared at the end of each operation
   assign counter_in = s1_ff.last_in ? '0 : INDEX_W'(counter_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_dest_ff <= '0;
         prev2_x_ff   <= '0;
         prev2_y_ff   <= '0;
         counter_ff   <= '0;
      end else if (advance) begin
         counter_ff <= counter_in;
         if (s1_ff.last_in) begin
            prev_x_ff    <= '0;
            prev_y_ff    <= '0;
            prev_dest_ff <= '0;
            prev2_x_ff   <= '0;
            prev2_y_ff   <= '0;
         end else begin
            prev2_x_ff   <= prev_x_ff;
            prev2_y_ff   <= prev_y_ff;
            prev_x_ff    <= s1_ff.x_byte;
            prev_y_ff    <= s1_ff.y_byte;
            prev_dest_ff <= s1_ff.old_dest_byte;
         end
      end
   end

   // result queue: up to two pushes and one pop per cycle
   assign push_a      = advance && (counter_ff != '0);
   assign push_b      = advance && s1_ff.last_in;
   assign pop         = rsp_ch.valid && rsp_ch.ready;
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);
   assign b_addr      = push_a ? wr_ptr_next : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_a && push_b) begin
         wr_ptr_in = ptr_inc(wr_ptr_next);
      end else if (push_a || push_b) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         rsp_mem[wr_ptr_ff] <= rsp_a;
      end
      if (push_b) begin
         rsp_mem[b_addr] <= rsp_b;
      end
   end

   // output word from the queue head
   assign rsp_ch.valid       = (count_ff != '0);
   assign rsp_ch.result_byte = rsp_mem[rd_ptr_ff].result_byte;
   assign rsp_ch.byte_index  = rsp_mem[rd_ptr_ff].byte_index;
   assign rsp_ch.last_out    = rsp_mem[rd_ptr_ff].last_out;

   // queue never holds more words than it has entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // a word that ends an operation restarts the byte count
   a_counter_clear: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ff.last_in |=> counter_ff == '0)
      else $error("byte counter not cleared after last word");

   // any other word moves the byte count on by one
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_ff.last_in |=> counter_ff == INDEX_W'($past(counter_ff) + 1'b1))
      else $error("byte counter skipped");

   // queue fill level drops by one on a pop with no push
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !push_a && !push_b && pop |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("queue count lost a pop");

endmodule

`default_nettype wire
